>>> sv/stk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants for the shell line tokenizer
// Byte codes, result kinds, error codes, lexer modes and queue entry layout.
// ----------------------------------------------------------------------------
package stk_pkg;

    // Field widths
    localparam int CH_W      = 8;
    localparam int KIND_W    = 4;
    localparam int ERR_W     = 2;
    localparam int TOK_W     = 8;
    localparam int WLEN_W    = 10;
    localparam int DEPTH_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;

    // Results per item and queue sizing
    localparam int MAX_RES   = 3;
    localparam int RCNT_W    = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD_LENGTH = 1'd1;
    localparam logic [TOK_W-1:0]     MAX_TOKENS_RST      = 8'd255;
    localparam logic [WLEN_W-1:0]    MAX_WORD_LENGTH_RST = 10'd1000;

    // Result kinds
    localparam logic [KIND_W-1:0] K_BYTE   = 4'd0;
    localparam logic [KIND_W-1:0] K_WEND   = 4'd1;
    localparam logic [KIND_W-1:0] K_SEMI   = 4'd2;
    localparam logic [KIND_W-1:0] K_AMP    = 4'd3;
    localparam logic [KIND_W-1:0] K_PIPE   = 4'd4;
    localparam logic [KIND_W-1:0] K_ANDAND = 4'd5;
    localparam logic [KIND_W-1:0] K_OROR   = 4'd6;
    localparam logic [KIND_W-1:0] K_GT     = 4'd7;
    localparam logic [KIND_W-1:0] K_APPEND = 4'd8;
    localparam logic [KIND_W-1:0] K_LT     = 4'd9;
    localparam logic [KIND_W-1:0] K_LPAREN = 4'd10;
    localparam logic [KIND_W-1:0] K_RPAREN = 4'd11;
    localparam logic [KIND_W-1:0] K_LINE   = 4'd12;
    localparam logic [KIND_W-1:0] K_ERROR  = 4'd13;

    // Error codes
    localparam logic [ERR_W-1:0] E_TOKENS = 2'd0;
    localparam logic [ERR_W-1:0] E_WORD   = 2'd1;
    localparam logic [ERR_W-1:0] E_QUOTE  = 2'd2;
    localparam logic [ERR_W-1:0] E_BRACE  = 2'd3;

    // Byte codes
    localparam logic [CH_W-1:0] CH_NUL      = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CH_W-1:0] CH_HASH     = 8'h23;
    localparam logic [CH_W-1:0] CH_AMP      = 8'h26;
    localparam logic [CH_W-1:0] CH_SQUOTE   = 8'h27;
    localparam logic [CH_W-1:0] CH_LPAREN   = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN   = 8'h29;
    localparam logic [CH_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [CH_W-1:0] CH_LT       = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT       = 8'h3E;
    localparam logic [CH_W-1:0] CH_BACKTICK = 8'h60;
    localparam logic [CH_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [CH_W-1:0] CH_PIPE     = 8'h7C;
    localparam logic [CH_W-1:0] CH_RBRACE   = 8'h7D;

    typedef enum logic [2:0] {
        LM_IDLE    = 3'd0,
        LM_WORD    = 3'd1,
        LM_QUOTE   = 3'd2,
        LM_QEND    = 3'd3,
        LM_BRACE   = 3'd4,
        LM_COMMENT = 3'd5,
        LM_SKIP    = 3'd6
    } lex_mode_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_GT   = 2'd1,
        OP_AMP  = 2'd2,
        OP_PIPE = 2'd3
    } pend_op_t;

    // What to do once a word byte has been appended
    typedef enum logic [2:0] {
        APP_WORD,
        APP_QUOTE,
        APP_QEND,
        APP_BRACE,
        APP_OPEN_SPAN
    } app_act_t;

    typedef struct packed {
        logic [TOK_W-1:0]  max_tokens;
        logic [WLEN_W-1:0] max_word_length;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   byte_value;
        logic [ERR_W-1:0]  error_code;
    } result_t;

    // One queue entry: all results caused by one input item, slot 0 first
    typedef struct packed {
        logic [RCNT_W-1:0]         count;
        result_t [MAX_RES-1:0]     res;
    } entry_t;

endpackage

>>> sv/stk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_front: lexer front end
// Takes one byte per cycle while the queue has room, advances the lexer
// state and pushes the results the byte causes into the queue as one entry.
// ----------------------------------------------------------------------------
module stk_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [stk_pkg::CH_W-1:0]  in_ch,
    output logic                      in_ready,
    input  stk_pkg::cfg_t             cfg,
    input  logic                      q_full,
    output logic                      q_push,
    output stk_pkg::entry_t           q_entry
);

    stk_pkg::lex_mode_t              mode_reg,  mode_next;
    stk_pkg::pend_op_t               pend_reg,  pend_next;
    logic                            bt_reg,    bt_next;
    logic [stk_pkg::DEPTH_W-1:0]     depth_reg, depth_next;
    logic [stk_pkg::TOK_W-1:0]       tok_reg,   tok_next;
    logic [stk_pkg::WLEN_W-1:0]      wlen_reg,  wlen_next;

    logic [stk_pkg::RCNT_W-1:0]                  emit_cnt;
    stk_pkg::result_t [stk_pkg::MAX_RES-1:0]     emit_res;
    logic                                        run_word;
    logic                                        run_idle;
    logic                                        app_req;
    stk_pkg::app_act_t                           app_act;
    logic                                        line_end;
    logic [stk_pkg::CH_W-1:0]                    pend_ch;
    logic                                        accept;

    function automatic stk_pkg::result_t mk_res(
        input logic [stk_pkg::KIND_W-1:0] kind,
        input logic [stk_pkg::CH_W-1:0]   b,
        input logic [stk_pkg::ERR_W-1:0]  err
    );
        stk_pkg::result_t r;
        r.kind       = kind;
        r.byte_value = b;
        r.error_code = err;
        return r;
    endfunction

    function automatic logic is_sep(input logic [stk_pkg::CH_W-1:0] c);
        return c == stk_pkg::CH_SPACE  || c == stk_pkg::CH_TAB    ||
               c == stk_pkg::CH_SEMI   || c == stk_pkg::CH_AMP    ||
               c == stk_pkg::CH_PIPE   || c == stk_pkg::CH_GT     ||
               c == stk_pkg::CH_LT     || c == stk_pkg::CH_LPAREN ||
               c == stk_pkg::CH_RPAREN || c == stk_pkg::CH_HASH   ||
               c == stk_pkg::CH_NUL;
    endfunction

    always_comb begin
        case (pend_reg)
            stk_pkg::OP_GT:  pend_ch = stk_pkg::CH_GT;
            stk_pkg::OP_AMP: pend_ch = stk_pkg::CH_AMP;
            default:         pend_ch = stk_pkg::CH_PIPE;
        endcase
    end

    // Next state: the byte may walk through these steps in fixed order: mode
    // dispatch, word continuation, idle handling, a single append, then line end.
    // At most one append happens per byte, so it is resolved once at the end.
    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        bt_next    = bt_reg;
        depth_next = depth_reg;
        tok_next   = tok_reg;
        wlen_next  = wlen_reg;
        emit_cnt   = '0;
        emit_res   = '0;
        run_word   = 1'b0;
        run_idle   = 1'b0;
        app_req    = 1'b0;
        app_act    = stk_pkg::APP_WORD;
        line_end   = 1'b0;

        case (mode_reg)
            stk_pkg::LM_WORD: begin
                run_word = 1'b1;
            end
            stk_pkg::LM_QUOTE: begin
                if (in_ch == stk_pkg::CH_NUL) begin
                    emit_res[emit_cnt] = mk_res(stk_pkg::K_ERROR, '0, stk_pkg::E_QUOTE);
                    emit_cnt = emit_cnt + 2'd1;
                    line_end = 1'b1;
                end else begin
                    app_req = 1'b1;
                    app_act = stk_pkg::APP_QUOTE;
                end
            end
            stk_pkg::LM_QEND: begin
                if (in_ch == stk_pkg::CH_SQUOTE) begin
                    app_req = 1'b1;
                    app_act = stk_pkg::APP_QEND;
                end else begin
                    mode_next = stk_pkg::LM_WORD;
                    run_word  = 1'b1;
                end
            end
            stk_pkg::LM_BRACE: begin
                if (in_ch == stk_pkg::CH_NUL) begin
                    emit_res[emit_cnt] = mk_res(stk_pkg::K_ERROR, '0, stk_pkg::E_BRACE);
                    emit_cnt = emit_cnt + 2'd1;
                    line_end = 1'b1;
                end else begin
                    app_req = 1'b1;
                    app_act = stk_pkg::APP_BRACE;
                end
            end
            stk_pkg::LM_COMMENT, stk_pkg::LM_SKIP: begin
                line_end = (in_ch == stk_pkg::CH_NUL);
            end
            default: begin
                // idle, possibly holding a one-character operator
                pend_next = stk_pkg::OP_NONE;
                if (pend_reg != stk_pkg::OP_NONE && in_ch == pend_ch) begin
                    case (pend_reg)
                        stk_pkg::OP_GT:
                            emit_res[emit_cnt] = mk_res(stk_pkg::K_APPEND, '0, '0);
                        stk_pkg::OP_AMP:
                            emit_res[emit_cnt] = mk_res(stk_pkg::K_ANDAND, '0, '0);
                        default:
                            emit_res[emit_cnt] = mk_res(stk_pkg::K_OROR, '0, '0);
                    endcase
                    emit_cnt = emit_cnt + 2'd1;
                end else begin
                    if (pend_reg != stk_pkg::OP_NONE) begin
                        case (pend_reg)
                            stk_pkg::OP_GT:
                                emit_res[emit_cnt] = mk_res(stk_pkg::K_GT, '0, '0);
                            stk_pkg::OP_AMP:
                                emit_res[emit_cnt] = mk_res(stk_pkg::K_AMP, '0, '0);
                            default:
                                emit_res[emit_cnt] = mk_res(stk_pkg::K_PIPE, '0, '0);
                        endcase
                        emit_cnt = emit_cnt + 2'd1;
                    end
                    mode_next = stk_pkg::LM_IDLE;
                    run_idle  = 1'b1;
                end
            end
        endcase

        // continuing a word
        if (run_word) begin
            if (bt_next && in_ch == stk_pkg::CH_LBRACE) begin
                bt_next = 1'b0;
                app_req = 1'b1;
                app_act = stk_pkg::APP_OPEN_SPAN;
            end else begin
                bt_next = 1'b0;
                if (is_sep(in_ch)) begin
                    emit_res[emit_cnt] = mk_res(stk_pkg::K_WEND, '0, '0);
                    emit_cnt  = emit_cnt + 2'd1;
                    mode_next = stk_pkg::LM_IDLE;
                    wlen_next = '0;
                    run_idle  = 1'b1;
                end else begin
                    app_req = 1'b1;
                    app_act = stk_pkg::APP_WORD;
                end
            end
        end

        // between tokens
        if (run_idle) begin
            if (in_ch == stk_pkg::CH_SPACE || in_ch == stk_pkg::CH_TAB) begin
                mode_next = mode_next;
            end else if (in_ch == stk_pkg::CH_NUL) begin
                line_end = 1'b1;
            end else if (in_ch == stk_pkg::CH_HASH) begin
                mode_next = stk_pkg::LM_COMMENT;
            end else if (tok_next >= cfg.max_tokens) begin
                emit_res[emit_cnt] = mk_res(stk_pkg::K_ERROR, '0, stk_pkg::E_TOKENS);
                emit_cnt  = emit_cnt + 2'd1;
                mode_next = stk_pkg::LM_SKIP;
                pend_next = stk_pkg::OP_NONE;
                bt_next   = 1'b0;
            end else begin
                tok_next = tok_next + 8'd1;
                case (in_ch)
                    stk_pkg::CH_SEMI: begin
                        emit_res[emit_cnt] = mk_res(stk_pkg::K_SEMI, '0, '0);
                        emit_cnt = emit_cnt + 2'd1;
                    end
                    stk_pkg::CH_LPAREN: begin
                        emit_res[emit_cnt] = mk_res(stk_pkg::K_LPAREN, '0, '0);
                        emit_cnt = emit_cnt + 2'd1;
                    end
                    stk_pkg::CH_RPAREN: begin
                        emit_res[emit_cnt] = mk_res(stk_pkg::K_RPAREN, '0, '0);
                        emit_cnt = emit_cnt + 2'd1;
                    end
                    stk_pkg::CH_LT: begin
                        emit_res[emit_cnt] = mk_res(stk_pkg::K_LT, '0, '0);
                        emit_cnt = emit_cnt + 2'd1;
                    end
                    stk_pkg::CH_GT:   pend_next = stk_pkg::OP_GT;
                    stk_pkg::CH_AMP:  pend_next = stk_pkg::OP_AMP;
                    stk_pkg::CH_PIPE: pend_next = stk_pkg::OP_PIPE;
                    default: begin
                        // new word; its first byte cannot be a separator
                        mode_next = stk_pkg::LM_WORD;
                        wlen_next = '0;
                        bt_next   = 1'b0;
                        app_req   = 1'b1;
                        app_act   = stk_pkg::APP_WORD;
                    end
                endcase
            end
        end

        // append one word byte, checking the length limit on every byte
        if (app_req) begin
            if (wlen_next >= cfg.max_word_length) begin
                emit_res[emit_cnt] = mk_res(stk_pkg::K_ERROR, '0, stk_pkg::E_WORD);
                emit_cnt  = emit_cnt + 2'd1;
                mode_next = stk_pkg::LM_SKIP;
                pend_next = stk_pkg::OP_NONE;
                bt_next   = 1'b0;
            end else begin
                wlen_next = wlen_next + 10'd1;
                emit_res[emit_cnt] = mk_res(stk_pkg::K_BYTE, in_ch, '0);
                emit_cnt = emit_cnt + 2'd1;
                case (app_act)
                    stk_pkg::APP_QUOTE: begin
                        if (in_ch == stk_pkg::CH_SQUOTE) begin
                            mode_next = stk_pkg::LM_QEND;
                        end
                    end
                    stk_pkg::APP_QEND: begin
                        mode_next = stk_pkg::LM_QUOTE;
                    end
                    stk_pkg::APP_BRACE: begin
                        if (in_ch == stk_pkg::CH_LBRACE) begin
                            depth_next = depth_next + 10'd1;
                        end else if (in_ch == stk_pkg::CH_RBRACE) begin
                            depth_next = depth_next - 10'd1;
                        end
                        if (depth_next == '0) begin
                            mode_next = stk_pkg::LM_WORD;
                        end
                    end
                    stk_pkg::APP_OPEN_SPAN: begin
                        mode_next  = stk_pkg::LM_BRACE;
                        depth_next = 10'd1;
                    end
                    default: begin
                        if (in_ch == stk_pkg::CH_SQUOTE) begin
                            mode_next = stk_pkg::LM_QUOTE;
                        end else if (in_ch == stk_pkg::CH_BACKTICK) begin
                            bt_next = 1'b1;
                        end
                    end
                endcase
            end
        end

        // line end always comes last and clears the line state
        if (line_end) begin
            emit_res[emit_cnt] = mk_res(stk_pkg::K_LINE, '0, '0);
            emit_cnt   = emit_cnt + 2'd1;
            mode_next  = stk_pkg::LM_IDLE;
            pend_next  = stk_pkg::OP_NONE;
            bt_next    = 1'b0;
            depth_next = '0;
            tok_next   = '0;
            wlen_next  = '0;
        end
    end

    // Outputs toward the queue
    always_comb begin
        in_ready      = !q_full;
        accept        = in_valid && !q_full;
        q_push        = accept && (emit_cnt != '0);
        q_entry.count = emit_cnt;
        q_entry.res   = emit_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= stk_pkg::LM_IDLE;
            pend_reg  <= stk_pkg::OP_NONE;
            bt_reg    <= 1'b0;
            depth_reg <= '0;
            tok_reg   <= '0;
            wlen_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            bt_reg    <= bt_next;
            depth_reg <= depth_next;
            tok_reg   <= tok_next;
            wlen_reg  <= wlen_next;
        end
    end

endmodule

>>> sv/stk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_queue: entry queue between lexer and result serializer
// Small synchronous FIFO; head is visible whenever the queue is not empty.
// ----------------------------------------------------------------------------
module stk_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  stk_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output stk_pkg::entry_t head,
    output logic            empty
);

    stk_pkg::entry_t                 mem_reg [stk_pkg::Q_DEPTH];
    logic [stk_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [stk_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [stk_pkg::Q_CNT_W-1:0]     cnt_reg,    cnt_next;
    logic                            do_push;
    logic                            do_pop;

    always_comb begin
        full        = (cnt_reg == stk_pkg::Q_CNT_W'(stk_pkg::Q_DEPTH));
        empty       = (cnt_reg == '0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> sv/stk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_back: result serializer
// Unpacks queue entries into single results, one per cycle unless stalled,
// into a registered output stage; marks the final result of each entry.
// ----------------------------------------------------------------------------
module stk_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  stk_pkg::entry_t               q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [stk_pkg::KIND_W-1:0]    m_kind,
    output logic [stk_pkg::CH_W-1:0]      m_byte_value,
    output logic [stk_pkg::ERR_W-1:0]     m_error_code,
    output logic                          m_last
);

    stk_pkg::entry_t                 hold_reg,       hold_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [stk_pkg::RCNT_W-1:0]      idx_reg,        idx_next;
    stk_pkg::result_t                out_reg,        out_next;
    logic                            last_reg,       last_next;
    logic                            valid_reg,      valid_next;

    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        valid_next      = valid_reg;
        q_pop           = 1'b0;
        if (!valid_reg || m_ready) begin
            if (hold_valid_reg) begin
                // rest of a multi-result entry
                out_next   = hold_reg.res[idx_reg];
                valid_next = 1'b1;
                if (idx_reg == hold_reg.count - 2'd1) begin
                    last_next       = 1'b1;
                    hold_valid_next = 1'b0;
                end else begin
                    last_next = 1'b0;
                    idx_next  = idx_reg + 2'd1;
                end
            end else if (!q_empty) begin
                q_pop      = 1'b1;
                out_next   = q_head.res[0];
                valid_next = 1'b1;
                if (q_head.count == 2'd1) begin
                    last_next = 1'b1;
                end else begin
                    last_next       = 1'b0;
                    hold_next       = q_head;
                    hold_valid_next = 1'b1;
                    idx_next        = 2'd1;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_kind       = out_reg.kind;
    assign m_byte_value = out_reg.byte_value;
    assign m_error_code = out_reg.error_code;
    assign m_last       = last_reg;

endmodule

>>> sv/shell_line_tokenizer.sv
`timescale 1ns / 1ps
// Path: a byte's results pass through the queue, then the output register.
// Throughput: one byte per cycle while each byte gives at most one result and
//   m_ready stays high; the output side delivers one result per cycle, so a
//   byte giving N results holds the output back, absorbed by a 4-entry queue.
// Reset: synchronous, active low; lexer back to idle, counters cleared,
//   max_tokens 255, max_word_length 1000, queue and output empty.
// ----------------------------------------------------------------------------
// shell_line_tokenizer: command-line tokenizer, one byte per item
// Front lexer classifies bytes and builds result entries; a short queue
// decouples it from the serializer that hands results out one at a time.
// ----------------------------------------------------------------------------
module shell_line_tokenizer (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [stk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stk_pkg::CFG_DAT_W-1:0]    cfg_data,
    // input bytes
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [stk_pkg::CH_W-1:0]         s_ch,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [stk_pkg::KIND_W-1:0]       m_kind,
    output logic [stk_pkg::CH_W-1:0]         m_byte_value,
    output logic [stk_pkg::ERR_W-1:0]        m_error_code,
    output logic                             m_last
);

    // Configuration registers. Writes must happen only while the block is idle;
    // the block itself does not enforce this. The lexer reads them directly.
    stk_pkg::cfg_t   cfg_reg, cfg_next;

    // Front to queue
    logic            q_push;
    stk_pkg::entry_t q_entry;
    logic            q_full;

    // Queue to back
    logic            q_pop;
    stk_pkg::entry_t q_head;
    logic            q_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                stk_pkg::REG_MAX_TOKENS:
                    cfg_next.max_tokens = cfg_data[stk_pkg::TOK_W-1:0];
                stk_pkg::REG_MAX_WORD_LENGTH:
                    cfg_next.max_word_length = cfg_data[stk_pkg::WLEN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_tokens      <= stk_pkg::MAX_TOKENS_RST;
            cfg_reg.max_word_length <= stk_pkg::MAX_WORD_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Lexer: one byte per cycle whenever the queue has room. The byte's
    // results (up to three) travel as a single queue entry.
    stk_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ch    (s_ch),
        .in_ready (s_ready),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    stk_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // Serializer: one result per cycle while m_ready allows, into the output
    // register, last set on the final result of each entry.
    stk_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_byte_value (m_byte_value),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

`ifndef NO_ASSERTIONS
    // Line end is always the final result of its byte.
    a_line_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == stk_pkg::K_LINE |-> m_last)
        else $error("line end result without last");

    // Only word bytes carry a byte value.
    a_byte_only_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != stk_pkg::K_BYTE |-> m_byte_value == '0)
        else $error("byte value on a non-byte result");

    // Only error results carry an error code.
    a_code_only_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != stk_pkg::K_ERROR |-> m_error_code == '0)
        else $error("error code on a non-error result");

    // Nothing is presented right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule
